// ===== src/sblp_pkg.sv =====
// Package for the serial boot loader protocol engine.
// Holds protocol codes, event kinds and the result record types.
// No dependencies.
package sblp_pkg;

  localparam logic [7:0] START_BYTE = 8'h93;
  localparam logic [7:0] END_BYTE   = 8'h39;
  localparam logic [7:0] RC_GOOD    = 8'h00;
  localparam logic [7:0] RC_BAD     = 8'hFF;
  localparam logic [7:0] RC_TOO_BIG = 8'h88;

  localparam logic [7:0] CMD_LOOPBACK = 8'd0;
  localparam logic [7:0] CMD_SETUP    = 8'd1;
  localparam logic [7:0] CMD_CHUNK    = 8'd2;
  localparam logic [7:0] CMD_FINAL    = 8'd3;
  localparam logic [7:0] CMD_JUMP     = 8'd4;
  localparam logic [7:0] NUM_CMDS     = 8'd5;

  localparam int unsigned MAX_CHUNK = 2048;
  localparam int unsigned LEN_W     = 12;

  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_FORWARD = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;
  localparam logic [1:0] KIND_JUMP    = 2'd3;

  localparam int unsigned MAX_RES   = 3;
  localparam int unsigned Q_DEPTH   = 4;
  localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [1:0]       event_kind;
    logic [7:0]       data_byte;
    logic [31:0]      target_address;
    logic [LEN_W-1:0] chunk_length;
    logic             commit_ok;
    logic             last_of_run;
  } res_t;

  typedef struct packed {
    logic [1:0]             n;
    res_t [MAX_RES-1:0]     item;
  } push_t;

endpackage

// ===== src/sblp_if.sv =====
// Valid/ready channel interfaces for the boot loader engine.
// Depends on sblp_pkg for the result field widths.
interface sblp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, rx_byte, input ready);
  modport sink   (input valid, rx_byte, output ready);
endinterface

interface sblp_out_if import sblp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [1:0]       event_kind;
  logic [7:0]       data_byte;
  logic [31:0]      target_address;
  logic [LEN_W-1:0] chunk_length;
  logic             commit_ok;
  logic             last_of_run;
  modport source (output valid, event_kind, data_byte, target_address, chunk_length,
                  commit_ok, last_of_run, input ready);
  modport sink   (input valid, event_kind, data_byte, target_address, chunk_length,
                  commit_ok, last_of_run, output ready);
endinterface

// ===== src/serial_boot_loader_protocol.sv =====
// Serial boot loader protocol engine, one received byte per transfer.
// With the queue empty, the first result of a byte is valid the cycle after it.
// Throughput: one byte per cycle while the four-entry result queue holds at most
// one record; after a byte giving two or three results, input is held off until
// the output side has drained the queue back to at most one record.
// Reset (rst_n low, synchronous) returns to idle and clears all protocol state.
module serial_boot_loader_protocol import sblp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  sblp_in_if.sink    in_chan,
  sblp_out_if.source out_chan
);

  logic               in_fire;
  push_t              push;
  res_t               head;
  logic               head_valid;
  logic [Q_CNT_W-1:0] count;

  assign in_chan.ready = (count <= Q_CNT_W'(Q_DEPTH - MAX_RES));
  assign in_fire       = in_chan.valid && in_chan.ready;

  sblp_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .rx_byte (in_chan.rx_byte),
    .push    (push)
  );

  sblp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_chan.ready),
    .head       (head),
    .head_valid (head_valid),
    .count      (count)
  );

  assign out_chan.valid          = head_valid;
  assign out_chan.event_kind     = head.event_kind;
  assign out_chan.data_byte      = head.data_byte;
  assign out_chan.target_address = head.target_address;
  assign out_chan.chunk_length   = head.chunk_length;
  assign out_chan.commit_ok      = head.commit_ok;
  assign out_chan.last_of_run    = head.last_of_run;

endmodule

// ===== src/sblp_step.sv =====
// Protocol state and per-byte decode: turns one received byte into up to
// three result records. Depends on sblp_pkg.
module sblp_step import sblp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  output push_t      push
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_CMD, PH_ECHO_LEN, PH_ECHO_DATA, PH_SETUP_ADDR, PH_SETUP_SIZE,
    PH_SETUP_SUM, PH_CHUNK_LEN, PH_CHUNK_DATA, PH_CHUNK_SUM, PH_JUMP_ADDR
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [1:0]       wcnt_r, wcnt_nxt;
  logic [31:0]      wshift_r, wshift_nxt;
  logic [31:0]      load_base_r, load_base_nxt;
  logic [31:0]      write_offset_r, write_offset_nxt;
  logic [31:0]      chunk_base_r, chunk_base_nxt;
  logic [7:0]       exp_sum_r, exp_sum_nxt;
  logic [31:0]      remaining_r, remaining_nxt;
  logic [LEN_W-1:0] chunk_idx_r, chunk_idx_nxt;
  logic [7:0]       chunk_sum_r, chunk_sum_nxt;
  logic [7:0]       comm_sum_r, comm_sum_nxt;

  logic [31:0]      word_base, word_new;
  logic             word_done, sum_ok;
  push_t            p;

  function automatic res_t mk_res(logic [1:0] kind, logic [7:0] data,
                                  logic [31:0] addr, logic [LEN_W-1:0] len,
                                  logic ok);
    res_t r;
    r.event_kind     = kind;
    r.data_byte      = data;
    r.target_address = addr;
    r.chunk_length   = len;
    r.commit_ok      = ok;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_tx(logic [7:0] data);
    return mk_res(KIND_TX, data, 32'd0, '0, 1'b0);
  endfunction

  assign word_base = (wcnt_r == 2'd0) ? 32'd0 : wshift_r;
  assign word_new  = word_base | ({24'd0, rx_byte} << {wcnt_r, 3'b000});
  assign word_done = (wcnt_r == 2'd3);
  assign sum_ok    = (rx_byte == chunk_sum_r);

  always_comb begin
    phase_nxt        = phase_r;
    wcnt_nxt         = wcnt_r;
    wshift_nxt       = wshift_r;
    load_base_nxt    = load_base_r;
    write_offset_nxt = write_offset_r;
    chunk_base_nxt   = chunk_base_r;
    exp_sum_nxt      = exp_sum_r;
    remaining_nxt    = remaining_r;
    chunk_idx_nxt    = chunk_idx_r;
    chunk_sum_nxt    = chunk_sum_r;
    comm_sum_nxt     = comm_sum_r;
    p.n              = 2'd0;
    p.item           = '0;

    case (phase_r)
      PH_IDLE: begin
        if (rx_byte == START_BYTE) phase_nxt = PH_CMD;
      end
      PH_CMD: begin
        wcnt_nxt   = 2'd0;
        wshift_nxt = 32'd0;
        if (rx_byte >= NUM_CMDS) begin
          p.item[0] = mk_tx(RC_BAD);
          p.item[1] = mk_tx(END_BYTE);
          p.n       = 2'd2;
          phase_nxt = PH_IDLE;
        end else if (rx_byte == CMD_LOOPBACK) begin
          phase_nxt = PH_ECHO_LEN;
        end else if (rx_byte == CMD_SETUP) begin
          phase_nxt = PH_SETUP_ADDR;
        end else if (rx_byte == CMD_CHUNK) begin
          phase_nxt = PH_CHUNK_LEN;
        end else if (rx_byte == CMD_FINAL) begin
          p.item[0] = mk_tx((comm_sum_r == exp_sum_r) ? RC_GOOD : exp_sum_r);
          p.item[1] = mk_tx(END_BYTE);
          p.n       = 2'd2;
          phase_nxt = PH_IDLE;
        end else begin
          phase_nxt = PH_JUMP_ADDR;
        end
      end
      PH_ECHO_LEN: begin
        wshift_nxt = word_new;
        wcnt_nxt   = wcnt_r + 2'd1;
        if (word_done) begin
          remaining_nxt = word_new;
          if (word_new == 32'd0) begin
            p.item[0] = mk_tx(RC_GOOD);
            p.item[1] = mk_tx(END_BYTE);
            p.n       = 2'd2;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_ECHO_DATA;
          end
        end
      end
      PH_ECHO_DATA: begin
        p.item[0]     = mk_tx(rx_byte);
        p.n           = 2'd1;
        remaining_nxt = remaining_r - 32'd1;
        if (remaining_r == 32'd1) begin
          p.item[1] = mk_tx(RC_GOOD);
          p.item[2] = mk_tx(END_BYTE);
          p.n       = 2'd3;
          phase_nxt = PH_IDLE;
        end
      end
      PH_SETUP_ADDR: begin
        wshift_nxt = word_new;
        wcnt_nxt   = wcnt_r + 2'd1;
        if (word_done) begin
          load_base_nxt  = word_new;
          chunk_base_nxt = word_new + write_offset_r;
          wshift_nxt     = 32'd0;
          phase_nxt      = PH_SETUP_SIZE;
        end
      end
      PH_SETUP_SIZE: begin
        wshift_nxt = word_new;
        wcnt_nxt   = wcnt_r + 2'd1;
        if (word_done) phase_nxt = PH_SETUP_SUM;
      end
      PH_SETUP_SUM: begin
        exp_sum_nxt = rx_byte;
        p.item[0]   = mk_tx(RC_GOOD);
        p.item[1]   = mk_tx(END_BYTE);
        p.n         = 2'd2;
        phase_nxt   = PH_IDLE;
      end
      PH_CHUNK_LEN: begin
        wshift_nxt = word_new;
        wcnt_nxt   = wcnt_r + 2'd1;
        if (word_done) begin
          remaining_nxt = word_new;
          chunk_idx_nxt = '0;
          chunk_sum_nxt = 8'd0;
          if (word_new > 32'(MAX_CHUNK)) begin
            p.item[0] = mk_tx(RC_TOO_BIG);
            p.item[1] = mk_tx(END_BYTE);
            p.n       = 2'd2;
            phase_nxt = PH_IDLE;
          end else if (word_new == 32'd0) begin
            phase_nxt = PH_CHUNK_SUM;
          end else begin
            phase_nxt = PH_CHUNK_DATA;
          end
        end
      end
      PH_CHUNK_DATA: begin
        p.item[0] = mk_res(KIND_FORWARD, rx_byte,
                           chunk_base_r + {{(32-LEN_W){1'b0}}, chunk_idx_r}, '0, 1'b0);
        p.n           = 2'd1;
        chunk_sum_nxt = chunk_sum_r + rx_byte;
        chunk_idx_nxt = chunk_idx_r + 1'b1;
        remaining_nxt = remaining_r - 32'd1;
        if (remaining_r == 32'd1) phase_nxt = PH_CHUNK_SUM;
      end
      PH_CHUNK_SUM: begin
        p.item[0] = mk_res(KIND_VERDICT, 8'd0, chunk_base_r, chunk_idx_r, sum_ok);
        p.item[1] = mk_tx(sum_ok ? RC_GOOD : chunk_sum_r);
        p.item[2] = mk_tx(END_BYTE);
        p.n       = 2'd3;
        phase_nxt = PH_IDLE;
        if (sum_ok) begin
          write_offset_nxt = write_offset_r + {{(32-LEN_W){1'b0}}, chunk_idx_r};
          chunk_base_nxt   = chunk_base_r + {{(32-LEN_W){1'b0}}, chunk_idx_r};
          comm_sum_nxt     = comm_sum_r + chunk_sum_r;
        end
      end
      PH_JUMP_ADDR: begin
        wshift_nxt = word_new;
        wcnt_nxt   = wcnt_r + 2'd1;
        if (word_done) begin
          p.item[0] = mk_res(KIND_JUMP, 8'd0, word_new, '0, 1'b0);
          p.item[1] = mk_tx(RC_BAD);
          p.item[2] = mk_tx(END_BYTE);
          p.n       = 2'd3;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    case (p.n)
      2'd1:    p.item[0].last_of_run = 1'b1;
      2'd2:    p.item[1].last_of_run = 1'b1;
      2'd3:    p.item[2].last_of_run = 1'b1;
      default: ;
    endcase

    if (!fire) p.n = 2'd0;
  end

  assign push = p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      wcnt_r         <= 2'd0;
      wshift_r       <= 32'd0;
      load_base_r    <= 32'd0;
      write_offset_r <= 32'd0;
      chunk_base_r   <= 32'd0;
      exp_sum_r      <= 8'd0;
      remaining_r    <= 32'd0;
      chunk_idx_r    <= '0;
      chunk_sum_r    <= 8'd0;
      comm_sum_r     <= 8'd0;
    end else if (fire) begin
      phase_r        <= phase_nxt;
      wcnt_r         <= wcnt_nxt;
      wshift_r       <= wshift_nxt;
      load_base_r    <= load_base_nxt;
      write_offset_r <= write_offset_nxt;
      chunk_base_r   <= chunk_base_nxt;
      exp_sum_r      <= exp_sum_nxt;
      remaining_r    <= remaining_nxt;
      chunk_idx_r    <= chunk_idx_nxt;
      chunk_sum_r    <= chunk_sum_nxt;
      comm_sum_r     <= comm_sum_nxt;
    end
  end

endmodule

// ===== src/sblp_queue.sv =====
// Result queue: takes up to three records per cycle, hands out one per transfer.
// Depends on sblp_pkg.
module sblp_queue import sblp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  push_t              push,
  input  logic               pop,
  output res_t               head,
  output logic               head_valid,
  output logic [Q_CNT_W-1:0] count
);

  res_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_pop;

  assign do_pop     = pop && (count_r != '0);
  assign count_nxt  = count_r + Q_CNT_W'(push.n) - Q_CNT_W'(do_pop);
  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign count      = count_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (i < int'(push.n)) mem_r[wr_ptr_r + Q_PTR_W'(i)] <= push.item[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + Q_PTR_W'(push.n);
      rd_ptr_r <= rd_ptr_r + Q_PTR_W'(do_pop);
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== src/sblp_checker.sv =====
// Port-level checks for the boot loader engine, bound to the top level.
// Depends on sblp_pkg and serial_boot_loader_protocol.
module sblp_checker import sblp_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       out_kind,
  input logic [7:0]       out_data,
  input logic [LEN_W-1:0] out_len,
  input logic             out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_data))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FORWARD |-> out_last && out_len == '0)
    else $error("forwarded byte not alone in its run");

  a_verdict_jump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_VERDICT || out_kind == KIND_JUMP)
      |-> !out_last && out_data == 8'd0)
    else $error("verdict or jump ends a run");

endmodule

bind serial_boot_loader_protocol sblp_checker u_sblp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.event_kind),
  .out_data  (out_chan.data_byte),
  .out_len   (out_chan.chunk_length),
  .out_last  (out_chan.last_of_run)
);
